// File: src/deq_pkg.sv
// Shared types for the double-ended queue: operation and status codes, transaction payloads, store request.
package deq_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT  = 2'd0,
    OP_POP_FRONT   = 2'd1,
    OP_INJECT_REAR = 2'd2,
    OP_EJECT_REAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [DataWidth-1:0] value;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [DataWidth-1:0] removed_value;
  } out_t;

  typedef struct packed {
    logic    we;
    logic    re;
    status_t status;
  } mem_req_t;

endpackage

// File: src/deq_mem.sv
// Element store: single-port synchronous RAM with registered read data.
module deq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/deq_ctrl.sv
// Front index and entry count tracking; decodes each transaction into a store access.
module deq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  deq_pkg::op_t             op,
  output deq_pkg::mem_req_t        req,
  output logic [$clog2(DEPTH)-1:0] addr
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty;
  logic [AW-1:0] front_dec, front_inc;
  logic [SW-1:0] rear_sum, last_sum;
  logic [AW-1:0] rear_slot, last_slot;

  always_comb begin
    full      = (count_r == CW'(DEPTH));
    empty     = (count_r == '0);
    front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
    front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
    rear_sum  = SW'(front_r) + SW'(count_r);
    last_sum  = rear_sum - 1'b1;
    rear_slot = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);
    last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
  end

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    addr       = front_r;
    req.we     = 1'b0;
    req.re     = 1'b0;
    req.status = STATUS_DONE;
    unique case (op)
      OP_PUSH_FRONT: begin
        addr = front_dec;
        if (full) begin
          req.status = STATUS_FULL;
        end else begin
          req.we    = accept;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_INJECT_REAR: begin
        addr = rear_slot;
        if (full) begin
          req.status = STATUS_FULL;
        end else begin
          req.we    = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        addr = front_r;
        if (empty) begin
          req.status = STATUS_EMPTY;
        end else begin
          req.re    = accept;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_EJECT_REAR: begin
        addr = last_slot;
        if (empty) begin
          req.status = STATUS_EMPTY;
        end else begin
          req.re    = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        req.status = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH) && front_r <= AW'(DEPTH - 1))
    else $error("entry count or front index out of range");

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req.status != STATUS_DONE |=> $stable(count_r) && $stable(front_r))
    else $error("refused transaction changed queue state");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req.we |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow entry count");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("read and write issued together");
`endif

endmodule

// File: src/double_ended_queue.sv
// Top level of the bounded double-ended queue: handshakes, result pipeline and store.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one operation per
//   transaction: push front, pop front, inject rear or eject rear, plus a
//   value for inserts. Every transaction yields exactly one result on the
//   output channel (out_valid/out_ready/out_data): a status (done, full or
//   empty) and, for a successful pop or eject, the removed element.
//   Result path: the read stage, where the single-port element store is
//   read, then the output register.
//   Throughput: one transaction per cycle while out_ready stays high; each
//   operation does at most one store access; front ops alone move the index.
//   Stall: a result held at the output lets one more transaction enter and
//   wait in the read stage; then in_ready drops until out_ready returns.
//   Reset (rst_n low, synchronous): queue empty, front index zero, no result
//   pending. The store is not cleared; only live entries are ever read.
//   ELEMENT_WIDTH sets the stored width; values are truncated or
//   zero-extended to it, results to 32 bits.
module double_ended_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::out_t out_data
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                     accept;
  mem_req_t                 req;
  logic [AW-1:0]            addr;
  logic [63:0]              val_ext;
  logic [ELEMENT_WIDTH-1:0] wdata, rdata;
  logic [63:0]              rd_ext;

  logic                     pend_r;
  status_t                  pend_status_r;
  logic                     pend_take_r;
  logic                     advance;

  logic                     out_valid_r;
  out_t                     out_data_r;

  assign advance  = pend_r && (!out_valid_r || out_ready);
  assign in_ready = !pend_r || advance;
  assign accept   = in_valid && in_ready;

  assign val_ext = {32'b0, in_data.value};
  assign wdata   = val_ext[ELEMENT_WIDTH-1:0];
  assign rd_ext  = 64'(rdata);

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (in_data.op),
    .req    (req),
    .addr   (addr)
  );

  deq_mem #(.DEPTH(DEPTH), .WIDTH(ELEMENT_WIDTH)) u_mem (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r <= 1'b1;
      end else if (advance) begin
        pend_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= req.status;
      pend_take_r   <= req.re;
    end
    if (advance) begin
      out_data_r.status        <= pend_status_r;
      out_data_r.removed_value <= pend_take_r ? rd_ext[DataWidth-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("held result was overwritten");

  a_pend_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !advance |=> pend_r)
    else $error("pending transaction dropped");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != STATUS_DONE |-> out_data_r.removed_value == '0)
    else $error("refused transaction returned data");
`endif

endmodule

// File: bench/deq_checker.sv
// Checker for the double-ended queue: watches both channels, predicts each result, compares.
module deq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  deq_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  deq_pkg::out_t out_data,
  output int unsigned   errors,
  output int unsigned   outstanding
);
  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [DataWidth-1:0] slots [DEPTH];
  logic [IdxW-1:0]      head;
  logic [IdxW:0]        fill;
  out_t                 awaited[$];
  int unsigned          err = 0;

  function automatic out_t deque_apply(in_t t);
    out_t r;
    r.status        = STATUS_DONE;
    r.removed_value = '0;
    case (t.op)
      OP_PUSH_FRONT, OP_INJECT_REAR: begin
        if (fill == DEPTH) begin
          r.status = STATUS_FULL;
        end else if (t.op == OP_PUSH_FRONT) begin
          head        = IdxW'((head + DEPTH - 1) % DEPTH);
          slots[head] = t.value;
          fill        = fill + 1'b1;
        end else begin
          slots[IdxW'((head + fill) % DEPTH)] = t.value;
          fill                                = fill + 1'b1;
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = STATUS_EMPTY;
        end else if (t.op == OP_POP_FRONT) begin
          r.removed_value = slots[head];
          head            = IdxW'((head + 1) % DEPTH);
          fill            = fill - 1'b1;
        end else begin
          r.removed_value = slots[IdxW'((head + fill - 1) % DEPTH)];
          fill            = fill - 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [DataWidth-1:0] want,
                                        logic [DataWidth-1:0] got);
    err++;
    if (err <= 100) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      head = '0;
      fill = '0;
      awaited.delete();
    end else begin
      // result side first: a result taken at this edge belongs to an older transaction
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          err++;
          if (err <= 100) begin
            $display("%0t: unexpected result, expected none got status %h removed_value %h",
                     $time, out_data.status, out_data.removed_value);
          end
        end else begin
          want = awaited.pop_front();
          if (out_data.status !== want.status) begin
            note_mismatch("status", DataWidth'(want.status), DataWidth'(out_data.status));
          end
          if (out_data.removed_value !== want.removed_value) begin
            note_mismatch("removed_value", want.removed_value, out_data.removed_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited.push_back(deque_apply(in_data));
      end
    end
    errors      <= err;
    outstanding <= awaited.size();
  end

endmodule

// File: bench/testbench.sv
// Testbench top for the double-ended queue: clock, reset, stimulus, output stalls and verdict.
module testbench;
  import deq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned RandomOps  = 1600;
  localparam int unsigned CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles = 0;

  double_ended_queue #(
    .DEPTH        (Depth),
    .ELEMENT_WIDTH(DataWidth)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  deq_checker #(
    .DEPTH(Depth)
  ) deq_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (mismatches),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // output back-pressure: bursts of ready, stalls mostly short, some long, some none
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 10);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:        stall_len = 0;
        6, 7, 8, 9, 10, 11, 12: stall_len = $urandom_range(1, 2);
        13, 14, 15, 16, 17, 18: stall_len = $urandom_range(3, 8);
        default:                 stall_len = $urandom_range(15, 40);
      endcase
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (stall_len != 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  task automatic send_op(op_t op, logic [DataWidth-1:0] v);
    int unsigned gap;
    in_data  <= '{op: op, value: v};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: gap = 0;
      6, 7, 8:          gap = $urandom_range(1, 3);
      default:          gap = $urandom_range(5, 25);
    endcase
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int unsigned          insert_pct;
    logic                 insert;
    logic                 at_rear;
    op_t                  op;
    logic [DataWidth-1:0] v;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    insert_pct = 50;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // removals from empty, extremes of the value, inject into empty
    send_op(OP_POP_FRONT, '1);
    send_op(OP_EJECT_REAR, '0);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_INJECT_REAR, '1);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_EJECT_REAR, '1);
    send_op(OP_INJECT_REAR, 32'hA5A5_5A5A);
    send_op(OP_POP_FRONT, '0);
    // fill from both ends, then inserts into a full queue, then removals from both ends
    for (int i = 0; i < Depth; i++) begin
      send_op(i[0] ? OP_INJECT_REAR : OP_PUSH_FRONT, $urandom);
    end
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_INJECT_REAR, '0);
    send_op(OP_EJECT_REAR, '0);
    send_op(OP_POP_FRONT, '0);
    drain_wait();

    for (int i = 0; i < RandomOps; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          2:       insert_pct = 85;
          default: insert_pct = 60;
        endcase
      end
      if (i == RandomOps / 2) begin
        drain_wait();
      end
      insert  = ($urandom_range(0, 99) < insert_pct);
      at_rear = 1'($urandom_range(0, 1));
      if (insert) begin
        op = at_rear ? OP_INJECT_REAR : OP_PUSH_FRONT;
      end else begin
        op = at_rear ? OP_EJECT_REAR : OP_POP_FRONT;
      end
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom;
      endcase
      send_op(op, v);
    end

    drain_wait();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
